>>> rtl/zobrist_position_hash_unit_macros.svh
// Assertion macros for the Zobrist position hash unit.
// Used by the modules that carry concurrent assertions; no other dependencies.
`ifndef ZOBRIST_POSITION_HASH_UNIT_MACROS_SVH
`define ZOBRIST_POSITION_HASH_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define ZPH_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("zph assertion failed");

`define ZPH_ASSERT_NEVER(label, clk, rst, expr) \
   `ZPH_ASSERT(label, clk, rst, !(expr))

`else

`define ZPH_ASSERT(label, clk, rst, prop)

`define ZPH_ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

>>> rtl/zph_pkg.sv
// Shared constants, types and command/status structs of the Zobrist hash unit.
// No dependencies.
`timescale 1ns / 1ps

package zph_pkg;

   localparam int SQUARES     = 64;
   localparam int PIECE_KINDS = 7;
   localparam int COLOR_KINDS = 3;
   localparam int EP_FILES    = 8;
   localparam int CASTLE_KEYS = 4;

   localparam int TABLE_KEYS  = SQUARES * PIECE_KINDS * COLOR_KINDS;
   localparam int SIDE_SLOT   = TABLE_KEYS;
   localparam int CASTLE_BASE = SIDE_SLOT + 1;
   localparam int FILE_BASE   = CASTLE_BASE + CASTLE_KEYS;
   localparam int KEY_DEPTH   = FILE_BASE + EP_FILES;

   localparam int KEY_W       = 64;
   localparam int KEY_AW      = $clog2(KEY_DEPTH);
   localparam int REQ_W       = 2;
   localparam int INDEX_W     = 11;
   localparam int SQ_W        = 6;
   localparam int KIND_W      = 3;
   localparam int COLOR_W     = 2;
   localparam int CASTLE_AW   = $clog2(CASTLE_KEYS);
   localparam int EP_AW       = (EP_FILES > 1) ? $clog2(EP_FILES) : 1;

   // closing sequence: side key, castling keys, file key
   localparam int CL_STEPS    = CASTLE_KEYS + 2;
   localparam int STEP_W      = $clog2(CL_STEPS);

   typedef logic [KEY_W-1:0]   key_type;
   typedef logic [KEY_AW-1:0]  key_addr_type;
   typedef logic [STEP_W-1:0]  step_type;

   localparam logic [REQ_W-1:0] REQ_WRITE  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_SQUARE = 2'd1;
   localparam logic [REQ_W-1:0] REQ_CLOSE  = 2'd2;

   localparam step_type STEP_SIDE   = step_type'(0);
   localparam step_type STEP_CASTLE = step_type'(1);
   localparam step_type STEP_FILE   = step_type'(CASTLE_KEYS + 1);

   typedef struct packed {
      logic     wr_en;
      logic     rd_square;
      logic     load_close;
      logic     rd_step;
      step_type step;
      logic     emit;
   } cmd_type;

   typedef struct packed {
      logic key_in_range;
      logic square_hit;
   } status_type;

endpackage

>>> rtl/zph_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module zph_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1357
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/zph_ctrl.sv
// Controller of the Zobrist hash unit: accepts transactions and sequences
// the closing key reads. Depends on zph_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "zobrist_position_hash_unit_macros.svh"

module zph_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [zph_pkg::REQ_W-1:0]   req_type,
   input  zph_pkg::status_type         status,
   output zph_pkg::cmd_type            cmd,
   output logic                        busy,
   output logic                        rsp_valid
);

   import zph_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DRAIN
   } state_type;

   state_type state_ff;
   state_type state_in;
   step_type  step_ff;
   step_type  step_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      accept;

   assign accept = start && (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_type == REQ_CLOSE)) begin
               state_in = ST_READ;
               step_in  = STEP_SIDE;
            end
         end
         ST_READ: begin
            step_in = step_ff + step_type'(1);
            if (step_ff == STEP_FILE) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= STEP_SIDE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      cmd.wr_en      = accept && (req_type == REQ_WRITE) && status.key_in_range;
      cmd.rd_square  = accept && (req_type == REQ_SQUARE) && status.square_hit;
      cmd.load_close = accept && (req_type == REQ_CLOSE);
      cmd.rd_step    = (state_ff == ST_READ);
      cmd.step       = step_ff;
      cmd.emit       = (state_ff == ST_DRAIN);
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `ZPH_ASSERT(a_close_goes_busy, clock, reset, (start && !busy && req_type == REQ_CLOSE) |=> busy)
   `ZPH_ASSERT(a_busy_from_close, clock, reset, $rose(busy) |-> $past(start && req_type == REQ_CLOSE))
   `ZPH_ASSERT(a_rsp_after_busy, clock, reset, rsp_valid |-> ($past(busy) && !busy))
   `ZPH_ASSERT_NEVER(a_no_write_while_busy, clock, reset, busy && (cmd.wr_en || cmd.rd_square))

endmodule

>>> rtl/zph_datapath.sv
// Datapath of the Zobrist hash unit: key store, address generation,
// accumulator and result register. Depends on zph_pkg and zph_ram.
`timescale 1ns / 1ps

module zph_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  zph_pkg::cmd_type              cmd,
   output zph_pkg::status_type           status,
   input  logic [zph_pkg::INDEX_W-1:0]   req_key_index,
   input  logic [zph_pkg::KEY_W-1:0]     req_key_value,
   input  logic [zph_pkg::SQ_W-1:0]      req_square,
   input  logic [zph_pkg::KIND_W-1:0]    req_piece_kind,
   input  logic [zph_pkg::COLOR_W-1:0]   req_piece_color,
   input  logic                          req_black_to_move,
   input  logic [zph_pkg::CASTLE_KEYS-1:0] req_castle_rights,
   input  logic                          req_ep_valid,
   input  logic [zph_pkg::SQ_W-1:0]      req_ep_square,
   output logic [zph_pkg::KEY_W-1:0]     rsp_position_hash
);

   import zph_pkg::*;

   key_type                acc_ff;
   key_type                acc_in;
   key_type                rsp_hash_ff;
   key_type                rsp_hash_in;
   logic                   hit_ff;
   logic                   hit_in;
   logic                   btm_ff;
   logic [CASTLE_KEYS-1:0] rights_ff;
   logic                   ep_hit_ff;
   logic [EP_AW-1:0]       ep_file_ff;
   key_addr_type           square_addr;
   key_addr_type           step_addr;
   key_addr_type           rd_addr;
   logic                   step_hit;
   step_type               castle_step;
   logic [CASTLE_AW-1:0]   castle_sel;
   logic                   rd_en;
   key_type                rd_data;
   key_type                xor_term;

   assign square_addr =
      key_addr_type'(req_square) * key_addr_type'(PIECE_KINDS * COLOR_KINDS)
      + key_addr_type'(req_piece_kind) * key_addr_type'(COLOR_KINDS)
      + key_addr_type'(req_piece_color);

   assign status.key_in_range = int'(req_key_index) < KEY_DEPTH;
   assign status.square_hit   = (req_piece_kind != '0)
                                && (int'(req_square) < SQUARES)
                                && (int'(req_piece_kind) < PIECE_KINDS)
                                && (int'(req_piece_color) < COLOR_KINDS);

   assign castle_step = cmd.step - STEP_CASTLE;
   assign castle_sel  = castle_step[CASTLE_AW-1:0];

   always_comb begin
      if (cmd.step == STEP_FILE) begin
         step_addr = key_addr_type'(FILE_BASE) + key_addr_type'(ep_file_ff);
         step_hit  = ep_hit_ff;
      end else if (cmd.step == STEP_SIDE) begin
         step_addr = key_addr_type'(SIDE_SLOT);
         step_hit  = btm_ff;
      end else begin
         step_addr = key_addr_type'(CASTLE_BASE) + key_addr_type'(castle_sel);
         step_hit  = rights_ff[castle_sel];
      end
   end

   assign rd_en   = cmd.rd_square || cmd.rd_step;
   assign rd_addr = cmd.rd_square ? square_addr : step_addr;
   assign hit_in  = cmd.rd_square || (cmd.rd_step && step_hit);

   zph_ram #(
      .WIDTH (KEY_W),
      .DEPTH (KEY_DEPTH)
   ) u_key_store (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (req_key_index[KEY_AW-1:0]),
      .wr_data (req_key_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign xor_term    = hit_ff ? rd_data : '0;
   assign acc_in      = cmd.emit ? '0 : (acc_ff ^ xor_term);
   assign rsp_hash_in = cmd.emit ? (acc_ff ^ xor_term) : rsp_hash_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         hit_ff <= 1'b0;
      end else begin
         acc_ff <= acc_in;
         hit_ff <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hash_ff <= rsp_hash_in;
      if (cmd.load_close) begin
         btm_ff     <= req_black_to_move;
         rights_ff  <= req_castle_rights;
         ep_hit_ff  <= req_ep_valid && (int'(req_ep_square) < SQUARES);
         ep_file_ff <= EP_AW'(req_ep_square % EP_FILES);
      end
   end

   assign rsp_position_hash = rsp_hash_ff;

endmodule

>>> rtl/zobrist_position_hash_unit.sv
// Zobrist position hash unit, top level.
// Depends on zph_pkg, zph_ctrl and zph_datapath.
//
// Usage: a transaction is taken at a rising edge with start high and busy low.
// req_type selects a key write (key_index, key_value), a square item (square,
// piece_kind, piece_color) or a closing item (black_to_move, castle_rights,
// ep_valid, ep_square). Load every key before it is used.
// Key writes and square items keep busy low, and the next transaction may
// follow at once. A square item's key is read from the key store and folded
// into the accumulator in the following cycle.
// A closing item keeps busy high while the side, four castling and file keys
// go through the single read port of the key store, one per cycle. The hash
// then shows on rsp_position_hash with rsp_valid high for one cycle, and the
// accumulator is cleared. Results cannot be stalled: the receiver takes each
// one in its cycle.
// Reset clears the controller and the accumulator; the key store keeps no
// reset value and must be loaded again.
`timescale 1ns / 1ps

module zobrist_position_hash_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [zph_pkg::REQ_W-1:0]       req_type,
   input  logic [zph_pkg::INDEX_W-1:0]     req_key_index,
   input  logic [zph_pkg::KEY_W-1:0]       req_key_value,
   input  logic [zph_pkg::SQ_W-1:0]        req_square,
   input  logic [zph_pkg::KIND_W-1:0]      req_piece_kind,
   input  logic [zph_pkg::COLOR_W-1:0]     req_piece_color,
   input  logic                            req_black_to_move,
   input  logic [zph_pkg::CASTLE_KEYS-1:0] req_castle_rights,
   input  logic                            req_ep_valid,
   input  logic [zph_pkg::SQ_W-1:0]        req_ep_square,
   output logic                            rsp_valid,
   output logic [zph_pkg::KEY_W-1:0]       rsp_position_hash
);

   import zph_pkg::*;

   cmd_type    cmd;
   status_type status;

   zph_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_type  (req_type),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   zph_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_key_index     (req_key_index),
      .req_key_value     (req_key_value),
      .req_square        (req_square),
      .req_piece_kind    (req_piece_kind),
      .req_piece_color   (req_piece_color),
      .req_black_to_move (req_black_to_move),
      .req_castle_rights (req_castle_rights),
      .req_ep_valid      (req_ep_valid),
      .req_ep_square     (req_ep_square),
      .rsp_position_hash (rsp_position_hash)
   );

endmodule

>>> verif/tb.sv
// Self-checking testbench for zobrist_position_hash_unit: loads the key store,
// then runs directed and random positions against a behavioral hash model.
// Depends on zph_pkg and the zobrist_position_hash_unit RTL.
`timescale 1ns / 1ps

module tb;
   import zph_pkg::*;

   localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 220;
   localparam int LOADED_SQUARES = 8;

   typedef struct {
      logic [REQ_W-1:0]       req;
      logic [INDEX_W-1:0]     key_index;
      logic [KEY_W-1:0]       key_value;
      logic [SQ_W-1:0]        square;
      logic [KIND_W-1:0]      piece_kind;
      logic [COLOR_W-1:0]     piece_color;
      logic                   black_to_move;
      logic [CASTLE_KEYS-1:0] castle_rights;
      logic                   ep_valid;
      logic [SQ_W-1:0]        ep_square;
   } hash_req_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [REQ_W-1:0]       req_type = '0;
   logic [INDEX_W-1:0]     req_key_index = '0;
   logic [KEY_W-1:0]       req_key_value = '0;
   logic [SQ_W-1:0]        req_square = '0;
   logic [KIND_W-1:0]      req_piece_kind = '0;
   logic [COLOR_W-1:0]     req_piece_color = '0;
   logic                   req_black_to_move = 1'b0;
   logic [CASTLE_KEYS-1:0] req_castle_rights = '0;
   logic                   req_ep_valid = 1'b0;
   logic [SQ_W-1:0]        req_ep_square = '0;
   logic                   rsp_valid;
   logic [KEY_W-1:0]       rsp_position_hash;

   key_type key_table [KEY_DEPTH];
   key_type running_hash = '0;
   key_type pending_hashes [$];
   int      mismatch_count = 0;
   int      cycle_count = 0;
   int      items_sent = 0;
   bit      burst_mode = 1'b0;

   zobrist_position_hash_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_key_index     (req_key_index),
      .req_key_value     (req_key_value),
      .req_square        (req_square),
      .req_piece_kind    (req_piece_kind),
      .req_piece_color   (req_piece_color),
      .req_black_to_move (req_black_to_move),
      .req_castle_rights (req_castle_rights),
      .req_ep_valid      (req_ep_valid),
      .req_ep_square     (req_ep_square),
      .rsp_valid         (rsp_valid),
      .rsp_position_hash (rsp_position_hash)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input key_type got, input key_type want);
      $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_hashes.size() == 0) begin
            report_mismatch("unexpected hash", rsp_position_hash, '0);
         end else begin
            if (rsp_position_hash !== pending_hashes[0])
               report_mismatch("position_hash", rsp_position_hash, pending_hashes[0]);
            void'(pending_hashes.pop_front());
         end
      end
   end

   // squares whose piece keys are loaded; square items only read these
   function automatic int loaded_square(input int n);
      case (n)
         0: return 0;
         1: return 1;
         2: return 5;
         3: return 21;
         4: return 42;
         5: return 58;
         6: return 62;
         default: return 63;
      endcase
   endfunction

   function automatic int pick_square();
      return loaded_square($urandom_range(0, LOADED_SQUARES - 1));
   endfunction

   function automatic bit slot_in_use(input int slot);
      int sq;
      bit hit;
      sq  = slot / (PIECE_KINDS * COLOR_KINDS);
      hit = 1'b0;
      if (slot >= SIDE_SLOT)
         return 1'b1;
      if ((slot / COLOR_KINDS) % PIECE_KINDS == 0)
         return 1'b0;
      for (int k = 0; k < LOADED_SQUARES; k++)
         if (loaded_square(k) == sq)
            hit = 1'b1;
      return hit;
   endfunction

   function automatic hash_req_type random_fields();
      hash_req_type r;
      r.req           = REQ_W'($urandom);
      r.key_index     = INDEX_W'($urandom);
      r.key_value     = {$urandom, $urandom};
      r.square        = SQ_W'($urandom);
      r.piece_kind    = KIND_W'($urandom);
      r.piece_color   = COLOR_W'($urandom);
      r.black_to_move = 1'($urandom);
      r.castle_rights = CASTLE_KEYS'($urandom);
      r.ep_valid      = 1'($urandom);
      r.ep_square     = SQ_W'($urandom);
      return r;
   endfunction

   task automatic fold_into_hash(input hash_req_type r);
      key_type h;
      int      slot;
      case (r.req)
         REQ_WRITE: begin
            if (int'(r.key_index) < KEY_DEPTH)
               key_table[r.key_index] = r.key_value;
         end
         REQ_SQUARE: begin
            if (r.piece_kind != 0 && int'(r.square) < SQUARES &&
                int'(r.piece_kind) < PIECE_KINDS && int'(r.piece_color) < COLOR_KINDS) begin
               slot = int'(r.square) * PIECE_KINDS * COLOR_KINDS +
                      int'(r.piece_kind) * COLOR_KINDS + int'(r.piece_color);
               running_hash ^= key_table[slot];
            end
         end
         REQ_CLOSE: begin
            h = running_hash;
            if (r.black_to_move)
               h ^= key_table[SIDE_SLOT];
            for (int i = 0; i < CASTLE_KEYS; i++)
               if (r.castle_rights[i])
                  h ^= key_table[CASTLE_BASE + i];
            if (r.ep_valid && int'(r.ep_square) < SQUARES)
               h ^= key_table[FILE_BASE + int'(r.ep_square) % EP_FILES];
            pending_hashes.push_back(h);
            running_hash = '0;
         end
         default: ;
      endcase
   endtask

   task automatic send_item(input hash_req_type r);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 7);
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start             <= 1'b1;
      req_type          <= r.req;
      req_key_index     <= r.key_index;
      req_key_value     <= r.key_value;
      req_square        <= r.square;
      req_piece_kind    <= r.piece_kind;
      req_piece_color   <= r.piece_color;
      req_black_to_move <= r.black_to_move;
      req_castle_rights <= r.castle_rights;
      req_ep_valid      <= r.ep_valid;
      req_ep_square     <= r.ep_square;
      do @(posedge clock); while (busy);
      fold_into_hash(r);
      items_sent++;
   endtask

   task automatic send_square(input int sq, input int kind, input int color);
      hash_req_type r;
      r = random_fields();
      r.req         = REQ_SQUARE;
      r.square      = SQ_W'(sq);
      r.piece_kind  = KIND_W'(kind);
      r.piece_color = COLOR_W'(color);
      send_item(r);
   endtask

   task automatic send_close(input bit btm, input int rights, input bit epv, input int eps);
      hash_req_type r;
      r = random_fields();
      r.req           = REQ_CLOSE;
      r.black_to_move = btm;
      r.castle_rights = CASTLE_KEYS'(rights);
      r.ep_valid      = epv;
      r.ep_square     = SQ_W'(eps);
      send_item(r);
   endtask

   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (pending_hashes.size() != 0) @(posedge clock);
   endtask

   task automatic load_key_store();
      hash_req_type r;
      int           n;
      n = 0;
      for (int slot = 0; slot < KEY_DEPTH; slot++) begin
         if (slot_in_use(slot)) begin
            r = random_fields();
            r.req       = REQ_WRITE;
            r.key_index = INDEX_W'(slot);
            if (n == 0)
               r.key_value = '1;
            else if (slot == KEY_DEPTH - 1)
               r.key_value = 64'h8000_0000_0000_0001;
            burst_mode = (n % 40) > 25;
            send_item(r);
            n++;
         end
      end
      burst_mode = 1'b0;
   endtask

   task automatic test_empty_and_full_close();
      send_close(1'b0, 0, 1'b0, 0);
      send_close(1'b1, 15, 1'b1, 63);
      send_close(1'b0, 5, 1'b1, 0);
      send_close(1'b1, 10, 1'b0, 7);
   endtask

   task automatic test_square_extremes();
      send_square(0, 1, 0);
      send_square(63, 6, 2);
      send_square(10, 0, 2);
      send_square(20, 7, 1);
      send_square(30, 3, 3);
      send_close(1'b0, 0, 1'b1, 56);
      burst_mode = 1'b1;
      send_square(63, 6, 2);
      send_square(63, 6, 2);
      send_square(1, 2, 1);
      send_close(1'b1, 3, 1'b1, 15);
      burst_mode = 1'b0;
   endtask

   task automatic test_ignored_requests();
      hash_req_type r;
      send_square(5, 4, 1);
      r = random_fields();
      r.req = REQ_UNUSED;
      send_item(r);
      r = random_fields();
      r.req       = REQ_WRITE;
      r.key_index = INDEX_W'(KEY_DEPTH);
      send_item(r);
      r.key_index = '1;
      send_item(r);
      send_close(1'b0, 12, 1'b0, 33);
   endtask

   task automatic test_key_rewrite();
      hash_req_type r;
      r = random_fields();
      r.req       = REQ_WRITE;
      r.key_index = INDEX_W'(SIDE_SLOT);
      r.key_value = '0;
      send_item(r);
      r.key_index = INDEX_W'(FILE_BASE + 7);
      r.key_value = {$urandom, $urandom};
      send_item(r);
      send_square(63, 6, 2);
      send_close(1'b1, 0, 1'b1, 47);
   endtask

   task automatic test_random_positions();
      hash_req_type r;
      int           target;
      int           squares;
      bit           paused;
      target = items_sent + RANDOM_ITEMS;
      paused = 1'b0;
      while (items_sent < target) begin
         burst_mode = ($urandom_range(0, 3) == 0);
         if (!paused && items_sent > target - RANDOM_ITEMS / 2) begin
            drain_results();
            paused = 1'b1;
         end
         if ($urandom_range(0, 5) == 0) begin
            r = random_fields();
            r.req       = REQ_WRITE;
            r.key_index = INDEX_W'($urandom_range(0, KEY_DEPTH - 1));
            send_item(r);
         end
         squares = $urandom_range(0, 20);
         for (int i = 0; i < squares; i++) begin
            case ($urandom_range(0, 9))
               0: begin
                  r = random_fields();
                  if (r.req == REQ_WRITE && int'(r.key_index) < KEY_DEPTH)
                     r.req = REQ_UNUSED;
                  if (r.req == REQ_SQUARE)
                     r.square = SQ_W'(pick_square());
                  send_item(r);
               end
               1: send_square(pick_square(), $urandom_range(0, 7), $urandom_range(0, 3));
               default:
                  send_square(pick_square(), $urandom_range(1, 6), $urandom_range(0, 2));
            endcase
         end
         send_close(1'($urandom), $urandom_range(0, 15), 1'($urandom), $urandom_range(0, 63));
      end
      burst_mode = 1'b0;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      load_key_store();
      test_empty_and_full_close();
      test_square_extremes();
      test_ignored_requests();
      test_key_rewrite();
      test_random_positions();
      drain_results();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

>>> zobrist_position_hash_unit.f
+incdir+rtl
rtl/zph_pkg.sv
rtl/zph_ram.sv
rtl/zph_ctrl.sv
rtl/zph_datapath.sv
rtl/zobrist_position_hash_unit.sv
verif/tb.sv
